// ----- rtl/ascon_pkg.sv -----
// Shared types, opcode codes and the round function of the ASCON state engine.
package ascon_pkg;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_XOR     = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_ZERO    = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_READ_X  = 3'd5;
  localparam logic [2:0] OP_PERMUTE = 3'd6;
  localparam logic [2:0] OP_NOP     = 3'd7;

  localparam int unsigned NUM_LANES   = 5;
  localparam logic [5:0]  STATE_BYTES = 6'd40;
  localparam logic [3:0]  NUM_ROUNDS  = 4'd12;
  localparam logic [3:0]  LAST_ROUND  = 4'd11;
  localparam logic [3:0]  RC_HI_BASE  = 4'hF;

  typedef logic [2:0] opcode_t;
  typedef logic [NUM_LANES-1:0][63:0] state_t;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    opcode_t    op;
    logic [2:0] lane;
    logic [2:0] pos;
    logic [7:0] data;
    logic [3:0] round;
    logic       last;
  } cmd_t;

  function automatic logic [63:0] rotr64(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic state_t ascon_round(state_t s, logic [3:0] r);
    logic [63:0] x0, x1, x2, x3, x4;
    logic [63:0] t0, t1, t2, t3, t4;
    state_t      res;
    x0 = s[0]; x1 = s[1]; x2 = s[2]; x3 = s[3]; x4 = s[4];
    x2 = x2 ^ {56'd0, RC_HI_BASE - r, r};
    // s-box layer
    x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
    t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
    x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
    x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
    // linear diffusion
    res[0] = x0 ^ rotr64(x0, 19) ^ rotr64(x0, 28);
    res[1] = x1 ^ rotr64(x1, 61) ^ rotr64(x1, 39);
    res[2] = x2 ^ rotr64(x2, 1)  ^ rotr64(x2, 6);
    res[3] = x3 ^ rotr64(x3, 10) ^ rotr64(x3, 17);
    res[4] = x4 ^ rotr64(x4, 7)  ^ rotr64(x4, 41);
    return res;
  endfunction

endpackage

// ----- rtl/ascon_if.sv -----
// Valid/ready channel interfaces for command words and result words.
interface ascon_in_if;
  import ascon_pkg::*;
  logic       valid;
  logic       ready;
  opcode_t    opcode;
  logic [5:0] byte_offset;
  logic [7:0] data_byte;
  logic [3:0] start_round;
  logic       last_byte;

  modport source (output valid, output opcode, output byte_offset, output data_byte,
                  output start_round, output last_byte, input ready);
  modport sink   (input valid, input opcode, input byte_offset, input data_byte,
                  input start_round, input last_byte, output ready);
endinterface

interface ascon_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

// ----- rtl/ascon_state_permutation_engine.sv -----
// Top level of the ASCON state engine: command queue front end and execution back end.
//
//   Channel  Dir  Handshake        Word
//   in_if    in   valid / ready    opcode, byte_offset, data_byte, start_round, last_byte
//   out_if   out  valid / ready    out_byte, last_out
//
// Byte words (clear, xor, write, zero, read, read-xor) are done as the back end takes them.
// A permute runs rounds start_round to 11, one round per cycle through a single
// round unit, during which the back end takes no new word; the front queue keeps accepting
// until its QUEUE_DEPTH entries are full. Every word gives one result word.
// Reset (rst_n low, synchronous) zeroes the state and empties the queue and result register.
// Result stall holds the result register; the queue fills behind it.
module ascon_state_permutation_engine #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  ascon_in_if.sink    in_if,
  ascon_out_if.source out_if
);
  import ascon_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  ascon_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  ascon_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

// ----- rtl/ascon_front.sv -----
// Front end: decode command words, turn no-effect ones into no-ops, queue them for the back end.
module ascon_front #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  ascon_in_if.sink         in_if,
  output logic             q_valid,
  output ascon_pkg::cmd_t  q_cmd,
  input  logic             q_pop
);
  import ascon_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;
  logic          byte_op;
  logic          drop;
  cmd_t          dec;

  assign in_if.ready = (cnt_r != CNT_FULL);
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    byte_op = (in_if.opcode == OP_XOR) || (in_if.opcode == OP_WRITE) ||
              (in_if.opcode == OP_ZERO) || (in_if.opcode == OP_READ) ||
              (in_if.opcode == OP_READ_X);
    // out-of-range bytes and late permutes leave the state alone
    drop = (byte_op && (in_if.byte_offset >= STATE_BYTES)) ||
           ((in_if.opcode == OP_PERMUTE) && (in_if.start_round >= NUM_ROUNDS));
    dec.op    = drop ? OP_NOP : in_if.opcode;
    dec.lane  = in_if.byte_offset[5:3];
    dec.pos   = in_if.byte_offset[2:0];
    dec.data  = in_if.data_byte;
    dec.round = in_if.start_round;
    dec.last  = in_if.last_byte;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];

endmodule

// ----- rtl/ascon_back.sv -----
// Back end: state register, byte access, one-round-per-cycle permutation and result register.
module ascon_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ascon_pkg::cmd_t q_cmd,
  output logic            q_pop,
  ascon_out_if.source     out_if
);
  import ascon_pkg::*;

  state_t      state_r, state_nxt;
  logic        busy_r, busy_nxt;
  logic [3:0]  round_r, round_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        last_r, last_nxt;
  logic [63:0] lane_word;
  logic [63:0] lane_upd;
  logic [5:0]  bit_base;
  logic [7:0]  cur_byte;

  assign q_pop = q_valid && !busy_r && (!out_valid_r || out_if.ready);

  always_comb begin
    bit_base  = {~q_cmd.pos, 3'b000};
    lane_word = state_r[q_cmd.lane];
    cur_byte  = lane_word[bit_base +: 8];
  end

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    round_nxt     = round_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;
    lane_upd      = lane_word;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (busy_r) begin
      state_nxt = ascon_round(state_r, round_r);
      round_nxt = round_r + 1'b1;
      busy_nxt  = (round_r != LAST_ROUND);
    end else if (q_pop) begin
      // result leaves at dispatch; a permute then holds the back end until done
      out_valid_nxt = 1'b1;
      out_byte_nxt  = 8'd0;
      last_nxt      = q_cmd.last;
      case (q_cmd.op)
        OP_CLEAR: begin
          state_nxt = '0;
        end
        OP_XOR: begin
          lane_upd[bit_base +: 8] = cur_byte ^ q_cmd.data;
          state_nxt[q_cmd.lane]   = lane_upd;
        end
        OP_WRITE: begin
          lane_upd[bit_base +: 8] = q_cmd.data;
          state_nxt[q_cmd.lane]   = lane_upd;
        end
        OP_ZERO: begin
          lane_upd[bit_base +: 8] = 8'd0;
          state_nxt[q_cmd.lane]   = lane_upd;
        end
        OP_READ: begin
          out_byte_nxt = cur_byte;
        end
        OP_READ_X: begin
          out_byte_nxt = cur_byte ^ q_cmd.data;
        end
        OP_PERMUTE: begin
          busy_nxt  = 1'b1;
          round_nxt = q_cmd.round;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      busy_r      <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.last_out = last_r;

endmodule

// ----- rtl/ascon_checker.sv -----
// Port-level checks of the ASCON state engine, bound to its top level.
module ascon_checker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 3);
  localparam logic [OW-1:0] MAX_OPEN = OW'(QUEUE_DEPTH + 1);

  logic [OW-1:0] open_r, open_nxt;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    open_nxt = open_r;
    if (in_acc && !out_acc) begin
      open_nxt = open_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      open_nxt = open_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != '0)
    else $error("result word without an accepted command word");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= MAX_OPEN)
    else $error("more words in flight than the queue and result register hold");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ascon_state_permutation_engine ascon_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready)
);
